>>> sv/cki_pkg.sv
// Shared constants and types for the color keyframe interpolator.
package cki_pkg;
    localparam int MaxSteps = 16;
    localparam int IdxW = $clog2(MaxSteps);
    localparam int CntW = $clog2(MaxSteps + 1);
    localparam int AgeW = 17;
    localparam int ColW = 64;
    localparam logic [16:0] AgeOne = 17'd65536;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // per-cell shift controls, broadcast along the row
    typedef struct packed {
        logic             ins;     // open a slot at pos
        logic             rem;     // close the slot at pos
        logic [IdxW:0]    pos;     // slot index
        logic [AgeW-1:0]  age;
        logic [ColW-1:0]  color;
    } cell_ctl_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;
endpackage

>>> sv/cki_cell.sv
// One keyframe cell: holds an age and a color; shifts with its neighbors.
module cki_cell (
    input  logic                        aclk,
    input  logic [cki_pkg::IdxW:0]      my_idx,
    input  cki_pkg::cell_ctl_t          ctl,
    input  logic [cki_pkg::AgeW-1:0]    left_age,
    input  logic [cki_pkg::ColW-1:0]    left_color,
    input  logic [cki_pkg::AgeW-1:0]    right_age,
    input  logic [cki_pkg::ColW-1:0]    right_color,
    output logic [cki_pkg::AgeW-1:0]    age_q,
    output logic [cki_pkg::ColW-1:0]    color_q
);
    logic [cki_pkg::AgeW-1:0] age_reg, age_next;
    logic [cki_pkg::ColW-1:0] color_reg, color_next;

    always_comb begin
        age_next = age_reg;
        color_next = color_reg;
        if (ctl.ins) begin
            if (my_idx == ctl.pos) begin
                age_next = ctl.age;
                color_next = ctl.color;
            end else if (my_idx > ctl.pos) begin
                age_next = left_age;
                color_next = left_color;
            end
        end else if (ctl.rem && my_idx >= ctl.pos) begin
            age_next = right_age;
            color_next = right_color;
        end
    end

    always_ff @(posedge aclk) begin
        age_reg <= age_next;
        color_reg <= color_next;
    end

    assign age_q = age_reg;
    assign color_q = color_reg;
endmodule

>>> sv/cki_div.sv
// Restoring divider: 16-bit quotient of (num << 16) / den, one bit a cycle.
module cki_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [15:0] quot
);
    logic [17:0] rem_reg, rem_next;
    logic [15:0] q_reg, q_next;
    logic [16:0] den_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;

    always_comb begin
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[16:0], 1'b0} - {1'b0, den_reg};
        if (start) begin
            rem_next = {1'b0, num};
            q_next = '0;
            cnt_next = 5'd15;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[17]) begin
                rem_next = trial;
                q_next = {q_reg[14:0], 1'b1};
            end else begin
                rem_next = {rem_reg[16:0], 1'b0};
                q_next = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) busy_next = 1'b0;
        end
    end

    // num < den so the quotient fits 16 bits; 16 shift-subtract steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start) den_reg <= den;
    end

    assign done = busy_reg && cnt_reg == 5'd0;
    assign quot = q_next;
endmodule

>>> sv/color_keyframe_interpolator_core.sv
// Top level of the color keyframe interpolator.
//  channel   | dir | beat contents
//  s_axis    | in  | tdata: command, age, red, green, blue, alpha, step_index
//  m_axis    | out | tdata: red_out..alpha_out, status, entry_count; tuser: color_valid
//  cfg       | in  | cfg_tdata: enabled
// Remove, full-table insert, disabled/empty eval and evals at or past either
// end go from the scan state straight to the output state. An insert walks
// the row one cell a cycle until it finds its slot, then shifts the row. An
// interpolated eval passes through the scan, divide, multiply and output states.
// One item at a time; the next beat is taken in the cycle after the result
// beat leaves. Reset empties the table and sets enabled.
// Output stall holds the result; no new beat is taken until it leaves.
module color_keyframe_interpolator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [19:2] age, [35:20] red, [51:36] green, [67:52] blue,
    // [83:68] alpha, [87:84] step_index
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] red_out, [31:16] green_out, [47:32] blue_out, [63:48] alpha_out,
    // [65:64] status, [70:66] entry_count
    output logic [71:0] m_tdata,
    // [0] color_valid
    output logic        m_tuser,
    input  logic        cfg_tvalid,
    output logic        cfg_tready,
    input  logic        cfg_tdata
);
    localparam int N = cki_pkg::MaxSteps;
    localparam int IW = cki_pkg::IdxW;
    localparam int CW = cki_pkg::CntW;

    cki_pkg::state_t state_reg, state_next;
    logic en_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0] cmd_reg;
    logic [16:0] age_reg;
    logic [63:0] col_reg;
    logic [3:0] sidx_reg;
    logic [IW:0] scan_reg, scan_next;   // current cell index
    logic [IW:0] hit_reg, hit_next;     // found position / bracket index
    logic found_reg, found_next;
    logic [15:0] f_reg;
    logic [63:0] res_col_reg, res_col_next;
    logic res_valid_reg, res_valid_next;
    logic [1:0] status_reg, status_next;
    logic m_valid_reg;
    cki_pkg::cell_ctl_t ctl;

    logic [16:0] ages [N+1];
    logic [63:0] cols [N+1];

    // row of cells; ages[N] is a dummy right neighbor
    assign ages[N] = '0;
    assign cols[N] = '0;
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [16:0] la;
            logic [63:0] lc;
            if (g == 0) begin : g_l0
                assign la = '0;
                assign lc = '0;
            end else begin : g_ln
                assign la = ages[g-1];
                assign lc = cols[g-1];
            end
            cki_cell u_cell (
                .aclk(aclk), .my_idx((IW+1)'(g)), .ctl(ctl),
                .left_age(la), .left_color(lc),
                .right_age(ages[g+1]), .right_color(cols[g+1]),
                .age_q(ages[g]), .color_q(cols[g])
            );
        end
    endgenerate

    // clamp incoming age
    logic [17:0] in_age;
    logic [16:0] in_age_c;
    always_comb begin
        in_age = s_tdata[19:2];
        if (in_age[17]) in_age_c = '0;
        else if (in_age[16:0] > cki_pkg::AgeOne) in_age_c = cki_pkg::AgeOne;
        else in_age_c = in_age[16:0];
    end

    // scan views: current cell and its right neighbor
    logic [IW-1:0] si;
    logic [16:0] a_cur, a_nxt;
    logic last_cur;
    always_comb begin
        si = scan_reg[IW-1:0];
        a_cur = ages[si];
        a_nxt = (scan_reg + 1'b1 < (IW+1)'(N)) ? ages[si + 1'b1] : '0;
        last_cur = (scan_reg + 1'b1 >= {1'b0, cnt_reg[CW-2:0]}) || cnt_reg[CW-1];
    end

    // divider; operands follow the bracket index as it is latched
    logic div_start, div_done;
    logic [15:0] div_q;
    logic [16:0] a0, a1;
    assign a0 = ages[hit_next[IW-1:0] - 1'b1];
    assign a1 = ages[hit_next[IW-1:0]];
    cki_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(age_reg - a0), .den(a1 - a0), .done(div_done), .quot(div_q)
    );

    function automatic logic [15:0] lerp(input logic [15:0] c0, input logic [15:0] c1,
                                         input logic [15:0] f);
        logic [31:0] p;
        begin
            if (c1 >= c0) begin
                p = (c1 - c0) * f;
                lerp = c0 + p[31:16];
            end else begin
                p = (c0 - c1) * f;
                p = p + 32'd65535;
                lerp = c0 - p[31:16];
            end
        end
    endfunction

    logic [63:0] c0, c1;
    assign c0 = cols[hit_reg[IW-1:0] - 1'b1];
    assign c1 = cols[hit_reg[IW-1:0]];

    logic s_fire;
    assign s_tready = state_reg == cki_pkg::S_IDLE && !m_valid_reg;
    assign s_fire = s_tvalid && s_tready;
    assign cfg_tready = 1'b1;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        scan_next = scan_reg;
        hit_next = hit_reg;
        found_next = found_reg;
        res_col_next = res_col_reg;
        res_valid_next = res_valid_reg;
        status_next = status_reg;
        div_start = 1'b0;
        ctl = '0;
        ctl.age = age_reg;
        ctl.color = col_reg;
        case (state_reg)
            cki_pkg::S_IDLE: begin
                if (s_fire) begin
                    scan_next = '0;
                    found_next = 1'b0;
                    hit_next = '0;
                    res_col_next = '0;
                    res_valid_next = 1'b0;
                    status_next = cki_pkg::ST_OK;
                    state_next = cki_pkg::S_SCAN;
                end
            end
            cki_pkg::S_SCAN: begin
                state_next = cki_pkg::S_OUT;
                case (cmd_reg)
                    cki_pkg::CMD_INSERT: begin
                        if (cnt_reg >= CW'(N)) status_next = cki_pkg::ST_FULL;
                        else if (scan_reg < (IW+1)'(cnt_reg) && !found_reg) begin
                            if (age_reg >= a_cur && (last_cur || age_reg <= a_nxt)) begin
                                hit_next = scan_reg + 1'b1;
                                found_next = 1'b1;
                            end
                            scan_next = scan_reg + 1'b1;
                            state_next = cki_pkg::S_SCAN;
                        end else begin
                            ctl.ins = 1'b1;
                            ctl.pos = hit_reg;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    cki_pkg::CMD_REMOVE: begin
                        if (CW'(sidx_reg) < cnt_reg) begin
                            ctl.rem = 1'b1;
                            ctl.pos = (IW+1)'(sidx_reg);
                            cnt_next = cnt_reg - 1'b1;
                        end else status_next = cki_pkg::ST_RANGE;
                    end
                    cki_pkg::CMD_EVAL: begin
                        if (en_reg && cnt_reg != '0) begin
                            res_valid_next = 1'b1;
                            if (age_reg <= ages[0]) res_col_next = cols[0];
                            else if (age_reg >= ages[IW'(cnt_reg - 1'b1)])
                                res_col_next = cols[IW'(cnt_reg - 1'b1)];
                            else if (scan_reg == '0) begin
                                scan_next = (IW+1)'(1);
                                state_next = cki_pkg::S_SCAN;
                            end else if ((IW+1)'(cnt_reg) > scan_reg + 1'b1
                                         && a_cur <= age_reg) begin
                                scan_next = scan_reg + 1'b1;
                                state_next = cki_pkg::S_SCAN;
                            end else begin
                                hit_next = scan_reg;
                                state_next = cki_pkg::S_DIV;
                                div_start = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            cki_pkg::S_DIV: begin
                if (div_done) state_next = cki_pkg::S_MUL;
            end
            cki_pkg::S_MUL: begin
                res_col_next = {lerp(c0[63:48], c1[63:48], f_reg),
                                lerp(c0[47:32], c1[47:32], f_reg),
                                lerp(c0[31:16], c1[31:16], f_reg),
                                lerp(c0[15:0], c1[15:0], f_reg)};
                state_next = cki_pkg::S_OUT;
            end
            cki_pkg::S_OUT: state_next = cki_pkg::S_IDLE;
            default: state_next = cki_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cki_pkg::S_IDLE;
            en_reg <= 1'b1;
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (cfg_tvalid) en_reg <= cfg_tdata;
            if (state_reg == cki_pkg::S_OUT) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
        scan_reg <= scan_next;
        hit_reg <= hit_next;
        found_reg <= found_next;
        res_col_reg <= res_col_next;
        res_valid_reg <= res_valid_next;
        status_reg <= status_next;
        if (div_done && state_reg == cki_pkg::S_DIV) f_reg <= div_q;
        if (s_fire) begin
            cmd_reg <= s_tdata[1:0];
            age_reg <= in_age_c;
            col_reg <= {s_tdata[35:20], s_tdata[51:36], s_tdata[67:52], s_tdata[83:68]};
            sidx_reg <= s_tdata[87:84];
        end
        if (state_reg == cki_pkg::S_OUT) begin
            m_tdata <= {1'b0, cnt_reg, status_reg, res_col_reg[15:0],
                        res_col_reg[31:16], res_col_reg[47:32], res_col_reg[63:48]};
            m_tuser <= res_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
endmodule

>>> bench/cki_scoreboard.sv
// Checker for the color keyframe interpolator: gradient table predictor and result compare.
module cki_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    input  logic        cfg_tvalid,
    input  logic        cfg_tready,
    input  logic        cfg_tdata,
    output int          fail_count,
    output int          pending,
    output int          colors_seen
);
    typedef struct packed {
        logic        color_valid;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } color_result_t;

    logic [16:0] grad_age [cki_pkg::MaxSteps];
    logic [63:0] grad_color [cki_pkg::MaxSteps];
    int          grad_count;
    logic        grad_enabled;
    color_result_t expected_colors[$];

    function automatic logic [16:0] clamp_age(logic [17:0] raw);
        if (raw[17]) return 17'd0;
        if (raw > 18'd65536) return cki_pkg::AgeOne;
        return raw[16:0];
    endfunction

    function automatic logic [15:0] blend(logic [15:0] c0, logic [15:0] c1, logic [15:0] f);
        logic [31:0] p;
        if (c1 >= c0) begin
            p = (c1 - c0) * f;
            return c0 + p[31:16];
        end
        p = (c0 - c1) * f;
        return c0 - 16'((33'(p) + 33'd65535) >> 16);
    endfunction

    function automatic color_result_t predict_color(logic [87:0] beat);
        color_result_t res;
        logic [1:0]  cmd;
        logic [16:0] age;
        logic [63:0] c, c0, c1;
        logic [3:0]  idx;
        logic [33:0] num;
        logic [16:0] f;
        int pos, n;
        res = '0;
        cmd = beat[1:0];
        age = clamp_age(beat[19:2]);
        idx = beat[87:84];
        if (cmd == cki_pkg::CMD_INSERT) begin
            if (grad_count >= cki_pkg::MaxSteps) begin
                res.status = cki_pkg::ST_FULL;
            end else begin
                pos = 0;
                for (int i = 0; i < grad_count; i++) begin
                    if (age >= grad_age[i] && (i + 1 >= grad_count || age <= grad_age[i+1])) begin
                        pos = i + 1;
                        break;
                    end
                end
                for (int i = grad_count; i > pos; i--) begin
                    grad_age[i] = grad_age[i-1];
                    grad_color[i] = grad_color[i-1];
                end
                grad_age[pos] = age;
                grad_color[pos] = {beat[35:20], beat[51:36], beat[67:52], beat[83:68]};
                grad_count++;
            end
        end else if (cmd == cki_pkg::CMD_REMOVE) begin
            if (idx < grad_count) begin
                for (int i = idx; i + 1 < grad_count; i++) begin
                    grad_age[i] = grad_age[i+1];
                    grad_color[i] = grad_color[i+1];
                end
                grad_count--;
            end else begin
                res.status = cki_pkg::ST_RANGE;
            end
        end else if (cmd == cki_pkg::CMD_EVAL && grad_enabled && grad_count > 0) begin
            res.color_valid = 1'b1;
            if (age <= grad_age[0]) begin
                c = grad_color[0];
            end else if (age >= grad_age[grad_count-1]) begin
                c = grad_color[grad_count-1];
            end else begin
                n = 1;
                while (n < grad_count - 1 && grad_age[n] <= age) n++;
                c0 = grad_color[n-1];
                c1 = grad_color[n];
                if (grad_age[n] > grad_age[n-1]) begin
                    num = 34'(age - grad_age[n-1]) << 16;
                    f = 17'(num / (grad_age[n] - grad_age[n-1]));
                end else begin
                    f = '0;
                end
                if (f > 17'd65535) f = 17'd65535;
                c = {blend(c0[63:48], c1[63:48], f[15:0]), blend(c0[47:32], c1[47:32], f[15:0]),
                     blend(c0[31:16], c1[31:16], f[15:0]), blend(c0[15:0], c1[15:0], f[15:0])};
            end
            {res.red, res.green, res.blue, res.alpha} = c;
        end
        res.entry_count = 5'(grad_count);
        return res;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        color_result_t e;
        if (!aresetn) begin
            grad_count = 0;
            grad_enabled = 1'b1;
            fail_count = 0;
            colors_seen <= 0;
        end else begin
            if (cfg_tvalid && cfg_tready) grad_enabled = cfg_tdata;
            if (s_tvalid && s_tready) expected_colors.push_back(predict_color(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("result beat with no expectation pending");
                    fail_count++;
                end else begin
                    e = expected_colors.pop_front();
                    if (m_tuser) colors_seen <= colors_seen + 1;
                    check_field("color_valid", e.color_valid, m_tuser);
                    check_field("red_out", e.red, m_tdata[15:0]);
                    check_field("green_out", e.green, m_tdata[31:16]);
                    check_field("blue_out", e.blue, m_tdata[47:32]);
                    check_field("alpha_out", e.alpha, m_tdata[63:48]);
                    check_field("status", e.status, m_tdata[65:64]);
                    check_field("entry_count", e.entry_count, m_tdata[70:66]);
                end
            end
        end
        pending = expected_colors.size();
    end
endmodule

>>> bench/tb_color_keyframe_interpolator_core.sv
// Testbench top: stimulus, flow control and verdict for the keyframe interpolator.
module tb_color_keyframe_interpolator_core;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        cfg_tvalid = 1'b0;
    logic        cfg_tready;
    logic        cfg_tdata = 1'b0;
    int          fail_count, pending, colors_seen;
    int          beats_sent = 0;
    int          hold_cycles = 0;   // forced receiver hold-off length

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    color_keyframe_interpolator_core u_top (.*);

    cki_scoreboard u_check (.*);

    // Receiver: random stall pattern, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || (beats_sent % 400 > 300);
        end
    end

    // Offer one beat and wait for its acceptance; valid stays up for the next
    // beat of the burst and is dropped by whoever idles the sender.
    task automatic send_beat(logic [1:0] cmd, logic [17:0] age, logic [63:0] rgba,
                             logic [3:0] idx);
        s_tdata <= {idx, rgba[15:0], rgba[31:16], rgba[47:32], rgba[63:48], age, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_enable(logic value);
        drain_results();
        cfg_tdata <= value;
        cfg_tvalid <= 1'b1;
        do @(posedge aclk); while (!cfg_tready);
        cfg_tvalid <= 1'b0;
    endtask

    function automatic logic [17:0] rand_age();
        case ($urandom_range(0, 9))
            0: return 18'($urandom_range(0, 262143));         // any, incl. negative
            1: return 18'h20000;                               // most negative
            2: return 18'd65536;
            3: return 18'h1FFFF;
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [63:0] rand_color();
        return {$urandom(), $urandom()};
    endfunction

    // Random burst: mostly inserts and evals, kept near a useful table size.
    task automatic random_burst(int len, int fill);
        int r;
        logic [1:0] cmd;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < fill) cmd = cki_pkg::CMD_INSERT;
            else if (r < fill + 15) cmd = cki_pkg::CMD_REMOVE;
            else if (r < 97) cmd = cki_pkg::CMD_EVAL;
            else cmd = 2'd3;                                   // unknown command
            send_beat(cmd, rand_age(), rand_color(), 4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table cases
        send_beat(cki_pkg::CMD_EVAL, 18'd100, '0, '0);
        send_beat(cki_pkg::CMD_REMOVE, '0, '0, 4'd0);
        send_beat(2'd3, '0, '1, 4'd15);
        // keys at both ends and in the middle, with extreme colors
        send_beat(cki_pkg::CMD_INSERT, 18'h20000, 64'h0000_FFFF_0000_FFFF, '0);
        send_beat(cki_pkg::CMD_INSERT, 18'h1FFFF, 64'hFFFF_0000_FFFF_0000, '0);
        send_beat(cki_pkg::CMD_INSERT, 18'd32768, 64'h8000_8000_0001_FFFE, '0);
        send_beat(cki_pkg::CMD_INSERT, 18'd32768, 64'h1234_5678_9ABC_DEF0, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'h3FFFF, '0, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'd0, '0, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'd65536, '0, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'd16384, '0, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'd49151, '0, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'd32768, '0, '0);
        send_beat(cki_pkg::CMD_REMOVE, '0, '0, 4'd15);
        send_beat(cki_pkg::CMD_REMOVE, '0, '0, 4'd1);
        // fill to full and try two more
        for (int i = 0; i < 14; i++)
            send_beat(cki_pkg::CMD_INSERT, rand_age(), rand_color(), '0);
        send_beat(cki_pkg::CMD_INSERT, 18'd5, '1, '0);
        send_beat(cki_pkg::CMD_EVAL, 18'd30000, '0, '0);
        send_beat(cki_pkg::CMD_REMOVE, '0, '0, 4'd15);

        write_enable(1'b0);
        send_beat(cki_pkg::CMD_EVAL, 18'd30000, '0, '0);
        write_enable(1'b1);

        // long receiver hold-off while the sender keeps offering
        hold_cycles = 300;
        random_burst(12, 40);

        // wait until everything came back, then continue
        drain_results();

        // random phase: bursts with gaps, occasional enable changes
        while (beats_sent < 1900) begin
            random_burst($urandom_range(1, 30), (beats_sent / 200) % 2 ? 30 : 55);
            if ($urandom_range(0, 1)) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
            if ($urandom_range(0, 24) == 0) write_enable(1'($urandom_range(0, 3) != 0));
        end
        write_enable(1'b1);
        drain_results();

        $display("Sent %0d beats; %0d interpolated colors checked over insert, remove,",
                 beats_sent, colors_seen);
        $display("evaluate, full table, bad index, unknown command and enable on/off.");
        if (fail_count == 0)
            $display("PASS color_keyframe_interpolator_core");
        else
            $display("FAIL color_keyframe_interpolator_core");
        $finish;
    end

    initial begin
        #1200000;
        $display("FAIL color_keyframe_interpolator_core");
        $finish;
    end
endmodule
